/* hdl/hla_pkg.sv */
// Shared types, constants and the trig ROM for the Hough line accumulator.
// Used by hla_cell, hough_line_accumulator_core and hla_checker.
package hla_pkg;

	localparam int ANGLE_BINS    = 136;
	localparam int DISTANCE_BINS = 138;
	localparam int IMAGE_SIDE    = 512;
	localparam int COUNT_BITS    = 20;

	localparam int PIX_W  = 9;
	localparam int IDX_W  = 8;
	localparam int ROM_W  = 18;
	localparam int PROD_W = PIX_W + 1 + ROM_W;
	localparam int RHO_W  = $clog2(IMAGE_SIDE) + 20;
	localparam int TW     = RHO_W - 1 + $clog2(DISTANCE_BINS + 1);
	localparam int Q_W    = $clog2(DISTANCE_BINS + 2) + 1;
	localparam int D_AW   = $clog2(DISTANCE_BINS);
	localparam int A_AW   = $clog2(ANGLE_BINS);

	localparam int CELL_DEPTH = 8;
	localparam int INS_LEN    = ANGLE_BINS + CELL_DEPTH + 2;
	localparam int CNT_W      = $clog2(INS_LEN + DISTANCE_BINS + 1);

	localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
	localparam logic [63:0] SQRT2_Q40  = 64'h0000016A09E667F3;
	localparam logic [63:0] STEP_Q60   = PI_Q60 / (64'd2 * 64'(ANGLE_BINS));
	localparam logic [63:0] RHO_HALF_U = (64'(IMAGE_SIDE) * SQRT2_Q40 + (64'd1 << 23)) >> 24;
	localparam logic [63:0] D2_U       = RHO_HALF_U << 1;
	localparam logic [63:0] INV_U      = (64'd1 << TW) / D2_U;
	localparam int          INV_W      = TW - $clog2(D2_U) + 1;

	localparam logic signed [RHO_W-1:0] RHO_HALF = RHO_W'(RHO_HALF_U);
	localparam logic [TW-1:0]           D2       = TW'(D2_U);
	localparam logic [INV_W-1:0]        INV      = INV_W'(INV_U);
	localparam logic [COUNT_BITS-1:0]   COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_UNUSED = 2'd3
	} hla_action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INSERT,
		ST_READ,
		ST_FETCH
	} hla_state_t;

	typedef struct packed {
		logic             vld;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} hla_chain_t;

	typedef struct packed {
		logic            rd_en;
		logic            clr_en;
		logic [D_AW-1:0] addr;
	} hla_ctrl_t;

	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
		logic [63:0] q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] al, ah, bl, bh, ll, m1, m2, hh, t, hi, lo;
		al = a & 64'hFFFFFFFF;
		ah = a >> 32;
		bl = b & 64'hFFFFFFFF;
		bh = b >> 32;
		ll = al * bl;
		m1 = ah * bl;
		m2 = al * bh;
		hh = ah * bh;
		t  = (ll >> 32) + (m1 & 64'hFFFFFFFF) + (m2 & 64'hFFFFFFFF);
		hi = hh + (m1 >> 32) + (m2 >> 32) + (t >> 32);
		lo = (t << 32) | (ll & 64'hFFFFFFFF);
		return (hi << 4) | (lo >> 60);
	endfunction

	function automatic logic signed [ROM_W-1:0] trig_rom(input int k, input logic want_sin);
		logic [63:0] x, x2, st, ss, ct, cs, mag, sa, ca, sel, v;
		int m, num;
		logic rneg, sneg, cneg, neg;
		logic signed [ROM_W-1:0] r;
		if (4 * k + ANGLE_BINS >= 4 * ANGLE_BINS) begin
			m = 2;
		end else if (4 * k + ANGLE_BINS >= 2 * ANGLE_BINS) begin
			m = 1;
		end else begin
			m = 0;
		end
		num  = 2 * k - m * ANGLE_BINS;
		rneg = num < 0;
		mag  = 64'(rneg ? -num : num);
		x    = mag * STEP_Q60;
		x2   = mul_q60(x, x);
		st   = x;
		ss   = x;
		ct   = 64'd1 << 60;
		cs   = 64'd1 << 60;
		for (int n = 1; n <= 13; n++) begin
			st = udiv64(mul_q60(st, x2), 64'(2 * n) * 64'(2 * n + 1));
			ct = udiv64(mul_q60(ct, x2), 64'(2 * n - 1) * 64'(2 * n));
			if ((n & 1) == 1) begin
				ss = ss - st;
				cs = cs - ct;
			end else begin
				ss = ss + st;
				cs = cs + ct;
			end
		end
		if (m == 0) begin
			sa = ss; sneg = rneg; ca = cs; cneg = 1'b0;
		end else if (m == 1) begin
			sa = cs; sneg = 1'b0; ca = ss; cneg = !rneg;
		end else begin
			sa = ss; sneg = !rneg; ca = cs; cneg = 1'b1;
		end
		sel = want_sin ? ca : sa;
		neg = want_sin ? !cneg : sneg;
		v   = (sel + (64'd1 << 43)) >> 44;
		r   = ROM_W'(v);
		return neg ? -r : r;
	endfunction

	function automatic logic [ANGLE_BINS*ROM_W-1:0] trig_tab(input logic want_sin);
		logic [ANGLE_BINS*ROM_W-1:0] tab;
		tab = '0;
		for (int k = 0; k < ANGLE_BINS; k++) begin
			tab[k*ROM_W +: ROM_W] = trig_rom(k, want_sin);
		end
		return tab;
	endfunction

	localparam logic [ANGLE_BINS*ROM_W-1:0] COS_TAB = trig_tab(1'b0);
	localparam logic [ANGLE_BINS*ROM_W-1:0] SIN_TAB = trig_tab(1'b1);

endpackage

/* hdl/hla_cell.sv */
// One angle cell: rho, distance bin and read-modify-write of its own count column.
// Depends on hla_pkg.
module hla_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [hla_pkg::ROM_W-1:0]    cos_k,
	input  logic signed [hla_pkg::ROM_W-1:0]    sin_k,
	input  hla_pkg::hla_chain_t                 chain_i,
	output hla_pkg::hla_chain_t                 chain_o,
	input  hla_pkg::hla_ctrl_t                  ctrl,
	output logic [hla_pkg::COUNT_BITS-1:0]      rd_q
);
	logic [hla_pkg::COUNT_BITS-1:0] mem_q [hla_pkg::DISTANCE_BINS];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [hla_pkg::PROD_W-1:0] px_s1, py_s1;
	logic signed [hla_pkg::RHO_W-1:0]  t_s2;
	logic                              neg_s3, neg_s4, neg_s5;
	logic [hla_pkg::TW-1:0]            tt_s3, tt_s4, tt_s5, qd_s5, rem;
	logic [hla_pkg::Q_W-1:0]           q_s4, q_s5, d_raw, d_sel;
	logic [hla_pkg::TW+hla_pkg::INV_W-1:0] qp;
	logic [hla_pkg::D_AW-1:0]          addr_s6, addr_s7, raddr, waddr;
	logic [hla_pkg::COUNT_BITS-1:0]    wdata;
	logic                              re, we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_o <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			chain_o <= chain_i;
			v_s1 <= chain_i.vld;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	assign qp    = (hla_pkg::TW + hla_pkg::INV_W)'(tt_s3) *
	               (hla_pkg::TW + hla_pkg::INV_W)'(hla_pkg::INV);
	assign rem   = tt_s5 - qd_s5;
	assign d_raw = q_s5 + hla_pkg::Q_W'(rem >= hla_pkg::D2);

	always_comb begin
		if (neg_s5) begin
			d_sel = '0;
		end else if (d_raw > hla_pkg::Q_W'(hla_pkg::DISTANCE_BINS - 1)) begin
			d_sel = hla_pkg::Q_W'(hla_pkg::DISTANCE_BINS - 1);
		end else begin
			d_sel = d_raw;
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= $signed({1'b0, chain_i.x}) * cos_k;
		py_s1  <= $signed({1'b0, chain_i.y}) * sin_k;
		t_s2   <= hla_pkg::RHO_W'(px_s1) + hla_pkg::RHO_W'(py_s1) + hla_pkg::RHO_HALF;
		neg_s3 <= t_s2[hla_pkg::RHO_W-1];
		tt_s3  <= t_s2[hla_pkg::RHO_W-1] ? '0 :
		          hla_pkg::TW'(t_s2[hla_pkg::RHO_W-2:0]) *
		          hla_pkg::TW'(hla_pkg::DISTANCE_BINS);
		q_s4   <= hla_pkg::Q_W'(qp >> hla_pkg::TW);
		tt_s4  <= tt_s3;
		neg_s4 <= neg_s3;
		qd_s5  <= hla_pkg::TW'(q_s4) * hla_pkg::D2;
		q_s5   <= q_s4;
		tt_s5  <= tt_s4;
		neg_s5 <= neg_s4;
		addr_s6 <= hla_pkg::D_AW'(d_sel);
		addr_s7 <= addr_s6;
	end

	assign re    = v_s6 | ctrl.rd_en;
	assign raddr = v_s6 ? addr_s6 : ctrl.addr;
	assign we    = v_s7 | ctrl.clr_en;
	assign waddr = ctrl.clr_en ? ctrl.addr : addr_s7;
	assign wdata = ctrl.clr_en ? '0 :
	               (rd_q == hla_pkg::COUNT_MAX) ? rd_q : rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

/* hdl/hough_line_accumulator_core.sv */
// Top level of the Hough line accumulator: control sequencer and the row of angle cells.
// Depends on hla_pkg and hla_cell.
//
// An insert transaction walks the pixel down a row of 136 angle cells, one cell per
// cycle, each doing a saturating read-modify-write on its own 138-entry count column;
// s_axis_tready stays low while an insert runs through the row and the cell pipeline.
// A read passes through the READ state, which reads the columns, and the FETCH state,
// which loads the output register once it is free; the next transaction is then accepted.
// A clear, and the clearing pass after reset, sweep all columns in parallel, during which
// s_axis_tready stays low. Out-of-range reads return zero.
module hough_line_accumulator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // pixel_x, pixel_y, angle_index, distance_index, zero pad
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // vote_count, zero pad
);
	hla_pkg::hla_state_t state_q, state_d;
	logic [hla_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic                           go_q, ok_q, load;
	logic [hla_pkg::PIX_W-1:0]      x_q, y_q;
	logic [hla_pkg::IDX_W-1:0]      ai_q, di_q;
	logic [hla_pkg::COUNT_BITS-1:0] vote_q;
	hla_pkg::hla_ctrl_t             ctrl;
	hla_pkg::hla_chain_t            chain [hla_pkg::ANGLE_BINS+1];
	logic [hla_pkg::COUNT_BITS-1:0] rdata [hla_pkg::ANGLE_BINS];
	logic                           acc;
	hla_pkg::hla_action_t           act;

	assign act = hla_pkg::hla_action_t'(s_axis_tuser);
	assign acc = s_axis_tvalid & s_axis_tready;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		s_axis_tready = 1'b0;
		load          = 1'b0;
		ctrl.rd_en    = 1'b0;
		ctrl.clr_en   = 1'b0;
		ctrl.addr     = hla_pkg::D_AW'(cnt_q);
		case (state_q)
			hla_pkg::ST_CLEAR: begin
				ctrl.clr_en = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == hla_pkg::CNT_W'(hla_pkg::DISTANCE_BINS - 1)) begin
					state_d = hla_pkg::ST_IDLE;
				end
			end
			hla_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cnt_d = '0;
				if (s_axis_tvalid) begin
					case (act)
						hla_pkg::ACT_INSERT: state_d = hla_pkg::ST_INSERT;
						hla_pkg::ACT_READ:   state_d = hla_pkg::ST_READ;
						hla_pkg::ACT_CLEAR:  state_d = hla_pkg::ST_CLEAR;
						default:             state_d = hla_pkg::ST_IDLE;
					endcase
				end
			end
			hla_pkg::ST_INSERT: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == hla_pkg::CNT_W'(hla_pkg::INS_LEN - 1)) begin
					state_d = hla_pkg::ST_IDLE;
				end
			end
			hla_pkg::ST_READ: begin
				ctrl.rd_en = ok_q;
				ctrl.addr  = hla_pkg::D_AW'(di_q);
				state_d    = hla_pkg::ST_FETCH;
			end
			hla_pkg::ST_FETCH: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					load    = 1'b1;
					state_d = hla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= hla_pkg::ST_CLEAR;
			cnt_q         <= '0;
			go_q          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			go_q    <= acc && act == hla_pkg::ACT_INSERT;
			if (load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_q  <= s_axis_tdata[8:0];
			y_q  <= s_axis_tdata[17:9];
			ai_q <= s_axis_tdata[25:18];
			di_q <= s_axis_tdata[33:26];
			ok_q <= s_axis_tdata[25:18] < hla_pkg::IDX_W'(hla_pkg::ANGLE_BINS) &&
			        s_axis_tdata[33:26] < hla_pkg::IDX_W'(hla_pkg::DISTANCE_BINS);
		end
		if (load) begin
			vote_q <= ok_q ? rdata[hla_pkg::A_AW'(ai_q)] : '0;
		end
	end

	assign chain[0] = '{vld: go_q, x: x_q, y: y_q};

	for (genvar g = 0; g < hla_pkg::ANGLE_BINS; g++) begin : g_cell
		hla_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cos_k   ($signed(hla_pkg::COS_TAB[g*hla_pkg::ROM_W +: hla_pkg::ROM_W])),
			.sin_k   ($signed(hla_pkg::SIN_TAB[g*hla_pkg::ROM_W +: hla_pkg::ROM_W])),
			.chain_i (chain[g]),
			.chain_o (chain[g+1]),
			.ctrl    (ctrl),
			.rd_q    (rdata[g])
		);
	end

	assign m_axis_tdata = {(24 - hla_pkg::COUNT_BITS)'(0), vote_q};

endmodule

/* hdl/hla_checker.sv */
// Port-level checks for hough_line_accumulator_core, bound to the top level.
// Depends on hla_pkg and hough_line_accumulator_core.
module hla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction dropped while stalled");

	a_insert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == hla_pkg::ACT_INSERT
		|=> !s_axis_tready)
		else $error("insert did not hold off input");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == hla_pkg::ACT_CLEAR
		|=> ##1 !s_axis_tready)
		else $error("clear did not hold off input");

	a_reset_clear: assert property (@(posedge clk)
		!$past(arst_n) |-> !s_axis_tready)
		else $error("input taken during reset clearing");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0)
		else $error("output padding not zero");

endmodule

bind hough_line_accumulator_core hla_checker u_hla_checker (.*);

/* tb/sv/tb.sv */
// Testbench for hough_line_accumulator_core: random inserts, reads, clears and idle codes.
// A scoreboard class keeps its own vote store and trig table and checks each read result.
// Depends on hla_pkg and the RTL of the core.
`timescale 1ns / 100ps

class vote_scoreboard;
	int          cos_q16[hla_pkg::ANGLE_BINS];
	int          sin_q16[hla_pkg::ANGLE_BINS];
	longint      rho_half;
	bit [19:0]   votes[hla_pkg::ANGLE_BINS * hla_pkg::DISTANCE_BINS];
	bit [19:0]   pending_counts[$];
	int          mismatches;

	function new();
		real th, v;
		for (int k = 0; k < hla_pkg::ANGLE_BINS; k++) begin
			th = -3.14159265358979323846 / 2.0 + k * 3.14159265358979323846 / hla_pkg::ANGLE_BINS;
			v = $cos(th) * 65536.0;
			cos_q16[k] = v >= 0.0 ? int'($floor(v + 0.5)) : -int'($floor(-v + 0.5));
			v = $sin(th) * 65536.0;
			sin_q16[k] = v >= 0.0 ? int'($floor(v + 0.5)) : -int'($floor(-v + 0.5));
		end
		rho_half = longint'((64'd512 * 64'h16A09E667F3 + (64'd1 << 23)) >> 24);
		clear_all();
		mismatches = 0;
	endfunction

	function void clear_all();
		foreach (votes[i]) votes[i] = '0;
	endfunction

	function void expect_count(bit [19:0] v);
		pending_counts = {pending_counts, v};
	endfunction

	function int distance_bin(int x, int y, int a);
		longint t, d;
		t = longint'(x) * cos_q16[a] + longint'(y) * sin_q16[a] + rho_half;
		d = t < 0 ? 0 : (t * hla_pkg::DISTANCE_BINS) / (2 * rho_half);
		if (d > hla_pkg::DISTANCE_BINS - 1) d = hla_pkg::DISTANCE_BINS - 1;
		return int'(d);
	endfunction

	function void note_item(logic [1:0] act, logic [39:0] data);
		int x, y, ai, di, adr;
		x  = data[8:0];
		y  = data[17:9];
		ai = data[25:18];
		di = data[33:26];
		case (act)
			hla_pkg::ACT_INSERT: begin
				for (int a = 0; a < hla_pkg::ANGLE_BINS; a++) begin
					adr = a + hla_pkg::ANGLE_BINS * distance_bin(x, y, a);
					if (votes[adr] != hla_pkg::COUNT_MAX) votes[adr]++;
				end
			end
			hla_pkg::ACT_READ: begin
				if (ai < hla_pkg::ANGLE_BINS && di < hla_pkg::DISTANCE_BINS)
					expect_count(votes[ai + hla_pkg::ANGLE_BINS * di]);
				else
					expect_count('0);
			end
			hla_pkg::ACT_CLEAR: clear_all();
			default: ;
		endcase
	endfunction

	function void check_count(logic [23:0] data);
		bit [19:0] want;
		if (pending_counts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result: vote_count %0d", data[19:0]);
			return;
		end
		want = pending_counts.pop_front();
		if (data[19:0] !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("vote_count mismatch: expected %0d, got %0d", want, data[19:0]);
		end
	endfunction
endclass

module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	vote_scoreboard votes_sb = new();
	int stall_mode = 0;
	int last_x = 0, last_y = 0;

	hough_line_accumulator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) votes_sb.check_count(m_axis_tdata);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task send_item(hla_pkg::hla_action_t act, int x, int y, int ai, int di);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {6'd0, di[7:0], ai[7:0], y[8:0], x[8:0]};
		do @(posedge clk); while (!s_axis_tready);
		votes_sb.note_item(act, {6'd0, di[7:0], ai[7:0], y[8:0], x[8:0]});
		if (act == hla_pkg::ACT_INSERT) begin
			last_x = x;
			last_y = y;
		end
	endtask

	task read_hit();
		int a;
		a = $urandom_range(0, hla_pkg::ANGLE_BINS - 1);
		send_item(hla_pkg::ACT_READ, $urandom, $urandom, a,
			votes_sb.distance_bin(last_x, last_y, a));
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (votes_sb.pending_counts.size() != 0) @(posedge clk);
	endtask

	initial begin
		int r, x0, y0, dx, dy, step;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(hla_pkg::ACT_READ, 0, 0, 0, 0);
		send_item(hla_pkg::ACT_READ, 511, 511, hla_pkg::ANGLE_BINS - 1,
			hla_pkg::DISTANCE_BINS - 1);
		send_item(hla_pkg::ACT_INSERT, 0, 0, 0, 0);
		send_item(hla_pkg::ACT_INSERT, 511, 511, 255, 255);
		send_item(hla_pkg::ACT_INSERT, 0, 511, 0, 0);
		send_item(hla_pkg::ACT_INSERT, 511, 0, 0, 0);
		send_item(hla_pkg::ACT_INSERT, 511, 0, 0, 0);
		read_hit();
		read_hit();
		send_item(hla_pkg::ACT_READ, 0, 0, 0, hla_pkg::DISTANCE_BINS / 2);
		send_item(hla_pkg::ACT_READ, 0, 0, hla_pkg::ANGLE_BINS - 1, 0);
		send_item(hla_pkg::ACT_READ, 0, 0, hla_pkg::ANGLE_BINS, 0);
		send_item(hla_pkg::ACT_READ, 0, 0, 0, hla_pkg::DISTANCE_BINS);
		send_item(hla_pkg::ACT_READ, 0, 0, 255, 255);
		send_item(hla_pkg::ACT_UNUSED, 511, 511, 255, 255);
		read_hit();
		send_item(hla_pkg::ACT_CLEAR, 0, 0, 0, 0);
		read_hit();
		send_item(hla_pkg::ACT_READ, 0, 0, 0, hla_pkg::DISTANCE_BINS / 2);
		drain();

		for (int n = 0; n < 700; n++) begin
			if (n == 350) drain();
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_item(hla_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
			end else if (r < 4) begin
				send_item(hla_pkg::ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end else if (r < 30) begin
				x0 = $urandom_range(0, 511);
				y0 = $urandom_range(0, 511);
				dx = $urandom_range(0, 4) - 2;
				dy = $urandom_range(0, 4) - 2;
				step = $urandom_range(2, 6);
				for (int p = 0; p < step; p++)
					send_item(hla_pkg::ACT_INSERT, (x0 + p * dx) & 511, (y0 + p * dy) & 511,
						0, 0);
				n += step - 1;
			end else if (r < 50) begin
				send_item(hla_pkg::ACT_INSERT, $urandom, $urandom, $urandom, $urandom);
			end else if (r < 85) begin
				read_hit();
			end else begin
				send_item(hla_pkg::ACT_READ, $urandom, $urandom, $urandom_range(0, 255),
					$urandom_range(0, 255));
			end
		end
		drain();
		repeat (300) @(posedge clk);
		if (votes_sb.mismatches == 0 && votes_sb.pending_counts.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

/* filelist.f */
hdl/hla_pkg.sv
hdl/hla_cell.sv
hdl/hough_line_accumulator_core.sv
hdl/hla_checker.sv
tb/sv/tb.sv
